### design/sfic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfic_pkg
// Shared types, widths and register codes of the state feedback controller.
// ----------------------------------------------------------------------------
package sfic_pkg;

  localparam int DataW    = 16;
  localparam int GainW    = 24;
  localparam int LimitW   = 15;
  localparam int IntegW   = 32;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 24;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_GAIN_ANGLE      = 3'd0,
    REG_GAIN_ANGLE_RATE = 3'd1,
    REG_GAIN_POSITION   = 3'd2,
    REG_GAIN_VELOCITY   = 3'd3,
    REG_GAIN_INTEGRAL   = 3'd4,
    REG_FORCE_LIMIT     = 3'd5,
    REG_POSITION_TARGET = 3'd6
  } cfg_reg_t;

  localparam logic [GainW-1:0]  GainAngleRst     = -24'sd970752;
  localparam logic [GainW-1:0]  GainAngleRateRst = -24'sd296598;
  localparam logic [GainW-1:0]  GainPositionRst  = -24'sd93657;
  localparam logic [GainW-1:0]  GainVelocityRst  = -24'sd107055;
  localparam logic [GainW-1:0]  GainIntegralRst  = 24'sd40960;
  localparam logic [LimitW-1:0] ForceLimitRst    = 15'd2560;
  localparam logic [DataW-1:0]  PosTargetRst     = 16'd0;

  typedef struct packed {
    logic [GainW-1:0]  gain_angle;
    logic [GainW-1:0]  gain_angle_rate;
    logic [GainW-1:0]  gain_position;
    logic [GainW-1:0]  gain_velocity;
    logic [GainW-1:0]  gain_integral;
    logic [LimitW-1:0] force_limit;
    logic [DataW-1:0]  position_target;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0] angle;
    logic [DataW-1:0] position;
    logic [DataW-1:0] angle_rate;
    logic [DataW-1:0] velocity;
    logic [DataW-1:0] tick_period;
    logic             run_req;
    logic             stop_request;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] force_res;
    logic             clamped;
  } out_item_t;

endpackage
`default_nettype wire

### design/sfic_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfic_in_if
// Valid/ready channel carrying one control tick of measurements and flags.
// ----------------------------------------------------------------------------
interface sfic_in_if;
  import sfic_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/sfic_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfic_out_if
// Valid/ready channel carrying the commanded force and clamp flag.
// ----------------------------------------------------------------------------
interface sfic_out_if;
  import sfic_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/sfic_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfic_cfg_regs
// Gain, limit and target registers written through the configuration port.
// ----------------------------------------------------------------------------
module sfic_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sfic_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [sfic_pkg::CfgDataW-1:0] cfg_wdata,
  output sfic_pkg::cfg_t                     cfg
);
  import sfic_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_GAIN_ANGLE:      cfg_nxt.gain_angle      = cfg_wdata[GainW-1:0];
        REG_GAIN_ANGLE_RATE: cfg_nxt.gain_angle_rate = cfg_wdata[GainW-1:0];
        REG_GAIN_POSITION:   cfg_nxt.gain_position   = cfg_wdata[GainW-1:0];
        REG_GAIN_VELOCITY:   cfg_nxt.gain_velocity   = cfg_wdata[GainW-1:0];
        REG_GAIN_INTEGRAL:   cfg_nxt.gain_integral   = cfg_wdata[GainW-1:0];
        REG_FORCE_LIMIT:     cfg_nxt.force_limit     = cfg_wdata[LimitW-1:0];
        REG_POSITION_TARGET: cfg_nxt.position_target = cfg_wdata[DataW-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_angle      <= GainAngleRst;
      cfg_r.gain_angle_rate <= GainAngleRateRst;
      cfg_r.gain_position   <= GainPositionRst;
      cfg_r.gain_velocity   <= GainVelocityRst;
      cfg_r.gain_integral   <= GainIntegralRst;
      cfg_r.force_limit     <= ForceLimitRst;
      cfg_r.position_target <= PosTargetRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### design/state_feedback_integral_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// state_feedback_integral_controller_top
// State feedback balance controller with integral action on position error.
//
// in_ch carries one control tick per transaction: angle, position, angle rate,
// velocity (signed Q4.12), tick period (Q0.16) and the run/stop flags.
// out_ch returns exactly one transaction per tick: the force (signed Q8.8)
// and a flag telling whether it hit the limit. cfg_* writes gains, limit and
// position target, one register per cycle, to be written only while no tick
// is in flight; the block does not enforce this. Ticks pass through three
// registers to out_ch: input register (loaded at the transaction), product
// register (the four feedback multipliers and the integral increment multiplier
// work in parallel), result register (integral-term multiplier, sum, clamp
// and integral update). One tick is taken every cycle unless stalled. Each
// stage holds its item while the next one is full and stalled, so bubbles
// are filled while out_ch is held off; in_ch.ready drops only when all three
// stages are full and out_ch.ready is low.
// Reset loads the default gains and clears the integral, the held force and
// the origin latch; the first tick after reset sets the position origin.
// ----------------------------------------------------------------------------
module state_feedback_integral_controller_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sfic_in_if.sink                            in_ch,
  sfic_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [sfic_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [sfic_pkg::CfgDataW-1:0] cfg_wdata
);
  import sfic_pkg::*;

  localparam int ProdW  = GainW + DataW;       // gain x measurement
  localparam int OffW   = DataW + 1;           // position offset / error
  localparam int PosPW  = GainW + OffW;
  localparam int IncPW  = OffW + DataW + 1;    // error x period, signed
  localparam int IncW   = IncPW - 4;
  localparam int IntPW  = GainW + IntegW;
  localparam int IntTW  = IntPW - 12;
  localparam int SumW   = 48;
  localparam int IAccW  = IntegW + 1;

  cfg_t cfg;

  sfic_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // pipeline control
  logic s0_valid_r, s1_valid_r, out_valid_r;
  logic out_adv, s1_ready, s0_ready;

  assign out_adv  = !out_valid_r || out_ch.ready;
  assign s1_ready = !s1_valid_r || out_adv;
  assign s0_ready = !s0_valid_r || s1_ready;
  assign in_ch.ready = s0_ready;

  // input register
  in_item_t s0_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_ch.valid) begin
      s0_data_r <= in_ch.data;
    end
  end

  // product stage
  logic [DataW-1:0] origin_r;
  logic             origin_latched_r;
  logic             s1_load;
  logic [DataW-1:0] origin_use;
  logic [OffW-1:0]  pos_off;
  logic [OffW-1:0]  pos_err;
  logic [ProdW-1:0] p_angle_nxt, p_rate_nxt, p_vel_nxt;
  logic [PosPW-1:0] p_pos_nxt;
  logic [IncPW-1:0] inc_prod;

  logic [ProdW-1:0] p_angle_r, p_rate_r, p_vel_r;
  logic [PosPW-1:0] p_pos_r;
  logic [IncW-1:0]  inc_r;
  logic             run_r, stop_r;

  assign s1_load    = s0_valid_r && s1_ready;
  // the first tick sees its own position as origin
  assign origin_use = origin_latched_r ? origin_r : s0_data_r.position;
  assign pos_off    = OffW'($signed(s0_data_r.position)) - OffW'($signed(origin_use));
  assign pos_err    = OffW'($signed(cfg.position_target))
                    - OffW'($signed(s0_data_r.position));

  assign p_angle_nxt = ProdW'($signed(cfg.gain_angle) * $signed(s0_data_r.angle));
  assign p_rate_nxt  = ProdW'($signed(cfg.gain_angle_rate) * $signed(s0_data_r.angle_rate));
  assign p_vel_nxt   = ProdW'($signed(cfg.gain_velocity) * $signed(s0_data_r.velocity));
  assign p_pos_nxt   = PosPW'($signed(cfg.gain_position) * $signed(pos_off));
  assign inc_prod    = IncPW'($signed(pos_err) * $signed({1'b0, s0_data_r.tick_period}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      origin_latched_r <= 1'b0;
      origin_r         <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= s0_valid_r;
      end
      if (s1_load && !origin_latched_r) begin
        origin_latched_r <= 1'b1;
        origin_r         <= s0_data_r.position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      p_angle_r <= p_angle_nxt;
      p_rate_r  <= p_rate_nxt;
      p_vel_r   <= p_vel_nxt;
      p_pos_r   <= p_pos_nxt;
      inc_r     <= inc_prod[IncPW-1:4];   // arithmetic shift, floor
      run_r     <= s0_data_r.run_req;
      stop_r    <= s0_data_r.stop_request;
    end
  end

  // result stage
  logic [IntegW-1:0] err_r, err_nxt;
  logic [DataW-1:0]  held_r, held_nxt;
  logic [IntPW-1:0]  int_prod;
  logic [IntTW-1:0]  int_term;
  logic [SumW-1:0]   sum, raw, lim, lim_neg;
  logic              in_range;
  logic [DataW-1:0]  lim16, calc_force;
  logic              calc_clamped;
  logic [IAccW-1:0]  err_sum;
  logic [IntegW-1:0] err_sat;
  logic              out_load;
  out_item_t         res_nxt, out_data_r;

  assign int_prod = IntPW'($signed(cfg.gain_integral) * $signed(err_r));
  assign int_term = int_prod[IntPW-1:12];

  assign sum = SumW'($signed(p_angle_r)) + SumW'($signed(p_rate_r))
             + SumW'($signed(p_pos_r)) + SumW'($signed(p_vel_r))
             + SumW'($signed(int_term));
  assign raw = -sum;

  assign lim      = {{(SumW-LimitW-16){1'b0}}, cfg.force_limit, 16'd0};
  assign lim_neg  = -lim;
  assign in_range = ($signed(raw) < $signed(lim)) && ($signed(raw) > $signed(lim_neg));
  assign lim16    = {1'b0, cfg.force_limit};

  always_comb begin
    if (in_range) begin
      calc_force   = raw[DataW+15:16];
      calc_clamped = 1'b0;
    end else begin
      calc_force   = raw[SumW-1] ? -lim16 : lim16;
      calc_clamped = 1'b1;
    end
  end

  // integral update with saturation to 32 bits
  assign err_sum = IAccW'($signed(err_r)) + IAccW'($signed(inc_r));
  always_comb begin
    if (err_sum[IAccW-1] != err_sum[IAccW-2]) begin
      err_sat = err_sum[IAccW-1] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      err_sat = err_sum[IntegW-1:0];
    end
  end

  always_comb begin
    err_nxt = err_r;
    held_nxt = held_r;
    res_nxt.force_res = held_r;
    res_nxt.clamped   = 1'b0;
    if (run_r && !stop_r) begin
      err_nxt           = err_sat;
      held_nxt          = calc_force;
      res_nxt.force_res = calc_force;
      res_nxt.clamped   = calc_clamped;
    end else if (!run_r && stop_r) begin
      err_nxt           = '0;
      held_nxt          = '0;
      res_nxt.force_res = '0;
    end
  end

  assign out_load = s1_valid_r && out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      err_r       <= '0;
      held_r      <= '0;
    end else begin
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (out_load) begin
        err_r  <= err_nxt;
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule
`default_nettype wire
